### design/mrc_pkg.sv
// Shared types, constants and helpers for the mixed-radix codec.
`default_nettype none
package mrc_pkg;

	localparam int FIELD_PLACES = 4;
	localparam int DIG_W        = 8;
	localparam int VAL_W        = 32;
	localparam int SUM_W        = 10;
	localparam int CNT_W        = 3;
	localparam int REM_W        = 10;

	localparam logic ACT_PACK   = 1'b0;
	localparam logic ACT_UNPACK = 1'b1;

	typedef enum logic [2:0] {
		REG_PLACE_COUNT = 3'd0,
		REG_RADIX_A     = 3'd1,
		REG_RADIX_B     = 3'd2,
		REG_RADIX_C     = 3'd3,
		REG_RADIX_D     = 3'd4,
		REG_BIG_ENDIAN  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic             action;
		logic [DIG_W-1:0] digit_a;
		logic [DIG_W-1:0] digit_b;
		logic [DIG_W-1:0] digit_c;
		logic [DIG_W-1:0] digit_d;
		logic [VAL_W-1:0] packed_in;
	} codec_in_t;

	typedef struct packed {
		logic [VAL_W-1:0] packed_out;
		logic [DIG_W-1:0] out_digit_a;
		logic [DIG_W-1:0] out_digit_b;
		logic [DIG_W-1:0] out_digit_c;
		logic [DIG_W-1:0] out_digit_d;
		logic [SUM_W-1:0] digit_sum;
		logic [VAL_W-1:0] combination_count;
	} codec_out_t;

	// Derived configuration; per-level fields are in significance order.
	typedef struct packed {
		logic [CNT_W-1:0]                   n;
		logic                               be;
		logic [FIELD_PLACES-1:0][DIG_W-1:0] rsig;
		logic [FIELD_PLACES-1:0][VAL_W-1:0] msig;
		logic [FIELD_PLACES-1:0][VAL_W-1:0] wsig;
		logic [VAL_W-1:0]                   prod;
	} cfg_t;

	typedef struct packed {
		logic             used;
		logic [DIG_W-1:0] r;
		logic [VAL_W-1:0] m;
		logic [VAL_W-1:0] w;
	} lvl_cfg_t;

	typedef struct packed {
		logic                               act;
		logic [VAL_W-1:0]                   x;
		logic [VAL_W-1:0]                   acc;
		logic [VAL_W-1:0]                   orig;
		logic [FIELD_PLACES-1:0][DIG_W-1:0] ds;
	} item_t;

	// Map between place index and significance index (the map is its own inverse).
	function automatic logic [1:0] place_of(input logic [CNT_W-1:0] n, input logic be,
		input logic [1:0] j);
		logic [CNT_W-1:0] t;
		t = n - 3'd1 - {1'b0, j};
		return be ? t[1:0] : j;
	endfunction

endpackage
`default_nettype wire

### design/mrc_cfg.sv
// Configuration registers plus reciprocal, weight and radix-product precompute.
`default_nettype none
module mrc_cfg import mrc_pkg::*; #(
	parameter int PLACES = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [2:0]       cfg_idx,
	input  logic [DIG_W-1:0] cfg_data,
	output logic             busy,
	output cfg_t             cfg
);

	localparam int DIV_STEPS = VAL_W + 1;
	localparam int STEP_W    = $clog2(DIV_STEPS);
	localparam int LIM_I     = (PLACES < 1) ? 1 : ((PLACES < FIELD_PLACES) ? PLACES : FIELD_PLACES);
	localparam logic [CNT_W-1:0] NLIM = CNT_W'(LIM_I);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_WGT  = 3'b100
	} seq_t;

	seq_t                               state_q;
	logic [CNT_W-1:0]                   place_count_q;
	logic [FIELD_PLACES-1:0][DIG_W-1:0] radix_q;
	logic                               be_q;
	logic [FIELD_PLACES-1:0][VAL_W-1:0] recip_q;
	logic [FIELD_PLACES-1:0][VAL_W-1:0] wsig_q;
	logic [VAL_W-1:0]                   prod_q;
	logic [1:0]                         place_q;
	logic [STEP_W-1:0]                  cnt_q;
	logic [DIG_W-1:0]                   rem_q;
	logic [VAL_W-1:0]                   quot_q;

	logic [FIELD_PLACES-1:0][DIG_W-1:0] reff;
	logic [CNT_W-1:0]                   n_c;
	logic [DIG_W-1:0]                   r_div;
	logic [DIG_W:0]                     sh;
	logic                               ge;
	logic [DIG_W-1:0]                   rem_nxt;
	logic [VAL_W-1:0]                   quot_nxt;

	always_comb begin
		for (int p = 0; p < FIELD_PLACES; p++) begin
			reff[p] = (radix_q[p] == '0) ? DIG_W'(1) : radix_q[p];
		end
	end

	always_comb begin
		if (place_count_q == '0) begin
			n_c = CNT_W'(1);
		end else if (place_count_q > NLIM) begin
			n_c = NLIM;
		end else begin
			n_c = place_count_q;
		end
	end

	always_comb begin
		logic [1:0] pl;
		cfg.n    = n_c;
		cfg.be   = be_q;
		cfg.wsig = wsig_q;
		cfg.prod = prod_q;
		for (int j = 0; j < FIELD_PLACES; j++) begin
			pl = place_of(n_c, be_q, 2'(j));
			if (CNT_W'(j) < n_c) begin
				cfg.rsig[j] = reff[pl];
				cfg.msig[j] = recip_q[pl];
			end else begin
				cfg.rsig[j] = DIG_W'(1);
				cfg.msig[j] = '1;
			end
		end
	end

	// One restoring step of floor(2^32 / r): the dividend is a one followed by zeros.
	assign r_div    = reff[place_q];
	assign sh       = {rem_q, (cnt_q == '0)};
	assign ge       = (sh >= {1'b0, r_div});
	assign rem_nxt  = ge ? DIG_W'(sh - {1'b0, r_div}) : sh[DIG_W-1:0];
	assign quot_nxt = {quot_q[VAL_W-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			place_count_q <= CNT_W'(4);
			radix_q       <= {FIELD_PLACES{DIG_W'(2)}};
			be_q          <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_PLACE_COUNT: place_count_q <= cfg_data[CNT_W-1:0];
				REG_RADIX_A:     radix_q[0] <= cfg_data;
				REG_RADIX_B:     radix_q[1] <= cfg_data;
				REG_RADIX_C:     radix_q[2] <= cfg_data;
				REG_RADIX_D:     radix_q[3] <= cfg_data;
				REG_BIG_ENDIAN:  be_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			place_q <= '0;
			cnt_q   <= '0;
			rem_q   <= '0;
			quot_q  <= '0;
			recip_q <= {FIELD_PLACES{VAL_W'(1) << (VAL_W - 1)}};
			prod_q  <= VAL_W'(1) << NLIM;
			for (int j = 0; j < FIELD_PLACES; j++) begin
				wsig_q[j] <= VAL_W'(1) << j;
			end
		end else if (cfg_wr_en) begin
			// restart the whole precompute on any write
			state_q <= ST_DIV;
			place_q <= '0;
			cnt_q   <= '0;
			rem_q   <= '0;
			quot_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: ;
				ST_DIV: begin
					if (cnt_q == STEP_W'(DIV_STEPS - 1)) begin
						recip_q[place_q] <= (r_div == DIG_W'(1)) ? '1 : quot_nxt;
						cnt_q            <= '0;
						rem_q            <= '0;
						quot_q           <= '0;
						place_q          <= place_q + 2'd1;
						if (place_q == 2'd3) begin
							state_q <= ST_WGT;
							prod_q  <= VAL_W'(1);
						end
					end else begin
						cnt_q  <= cnt_q + STEP_W'(1);
						rem_q  <= rem_nxt;
						quot_q <= quot_nxt;
					end
				end
				ST_WGT: begin
					wsig_q[place_q] <= prod_q;
					prod_q          <= VAL_W'(prod_q * VAL_W'(cfg.rsig[place_q]));
					place_q         <= place_q + 2'd1;
					if (place_q == 2'd3) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);

	a_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |=> busy)
		else $error("config write did not raise busy");

	a_div_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q <= STEP_W'(DIV_STEPS - 1)))
		else $error("divider step count out of range");

	a_wgt_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WGT && place_q == 2'd3 && !cfg_wr_en) |=> (state_q == ST_IDLE))
		else $error("precompute did not finish after last weight");

endmodule
`default_nettype wire

### design/mrc_level.sv
// One significance level: multiply, quotient estimate, correction (three stages).
`default_nettype none
module mrc_level import mrc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  lvl_cfg_t lc,
	input  logic     in_vld,
	input  item_t    in_item,
	output logic     out_vld,
	output item_t    out_item
);

	logic               vld_s1, vld_s2, vld_s3;
	item_t              itm_s1, itm_s2, itm_s3;
	logic [2*VAL_W-1:0] mul_s1;
	logic [VAL_W-1:0]   q_s2;
	logic [REM_W-1:0]   rem_s2;

	logic [VAL_W-1:0]   opa, opb;
	logic [2*VAL_W-1:0] mul;
	logic [VAL_W-1:0]   qest;
	logic [REM_W-1:0]   qr_lo;
	logic [REM_W-1:0]   rem;
	item_t              nxt2, nxt3;
	logic               ge;
	logic [DIG_W-1:0]   dig;

	// unpack: x times reciprocal; pack: digit times place weight
	assign opa = (in_item.act == ACT_UNPACK) ? in_item.x : VAL_W'(in_item.ds[0]);
	assign opb = (in_item.act == ACT_UNPACK) ? lc.m : lc.w;
	assign mul = opa * opb;

	assign qest  = mul_s1[2*VAL_W-1:VAL_W];
	assign qr_lo = qest[REM_W-1:0] * {2'b00, lc.r};
	assign rem   = itm_s1.x[REM_W-1:0] - qr_lo;

	always_comb begin
		nxt2 = itm_s1;
		if (itm_s1.act == ACT_PACK) begin
			nxt2.acc = itm_s1.acc + mul_s1[VAL_W-1:0];
		end
	end

	// estimate is low by at most one: fix up, then rotate the digit lanes
	assign ge = (rem_s2 >= {2'b00, lc.r});

	always_comb begin
		nxt3 = itm_s2;
		dig  = itm_s2.ds[0];
		if (itm_s2.act == ACT_UNPACK && lc.used) begin
			if (ge) begin
				nxt3.x = q_s2 + VAL_W'(1);
				dig    = DIG_W'(rem_s2 - {2'b00, lc.r});
			end else begin
				nxt3.x = q_s2;
				dig    = rem_s2[DIG_W-1:0];
			end
		end
		nxt3.ds = {dig, itm_s2.ds[FIELD_PLACES-1:1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		itm_s1 <= in_item;
		mul_s1 <= mul;
		itm_s2 <= nxt2;
		q_s2   <= qest;
		rem_s2 <= rem;
		itm_s3 <= nxt3;
	end

	assign out_vld  = vld_s3;
	assign out_item = itm_s3;

endmodule
`default_nettype wire

### design/mixed_radix_codec_core.sv
// An accepted transaction passes the input register, the four levels, the tail multiply stage
// and the output register before done/result show it. Throughput: one transaction per cycle while busy is low.
// The four division/weight levels are three stages each, set by one 32x32 multiplier per
// level; a final stage multiplies the quotient by the radix product for the unpack value.
// After any config write, busy stays high while the shared reciprocal divider works through
// each place and then the weight multiplier runs. Reset restores defaults.
`default_nettype none
module mixed_radix_codec_core import mrc_pkg::*; #(
	parameter int PLACES = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  codec_in_t        operand,
	output logic             done,
	output codec_out_t       result,
	input  logic             cfg_wr_en,
	input  logic [2:0]       cfg_idx,
	input  logic [DIG_W-1:0] cfg_data
);

	localparam int LAT = 15;

	cfg_t             cfg;
	logic             vld_s1;
	item_t            itm_s1;
	logic             lvl_vld [FIELD_PLACES+1];
	item_t            lvl_item [FIELD_PLACES+1];
	lvl_cfg_t         lvl_c [FIELD_PLACES];
	logic             vld_s14;
	item_t            itm_s14;
	logic [VAL_W-1:0] t_s14;
	logic             done_q;
	codec_out_t       res_q;

	item_t            in_c;
	codec_out_t       res_c;

	mrc_cfg #(
		.PLACES(PLACES)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.busy     (busy),
		.cfg      (cfg)
	);

	// clamp digits and order them least significant first
	always_comb begin
		logic [FIELD_PLACES-1:0][DIG_W-1:0] din;
		logic [1:0]                         pl;
		logic [DIG_W-1:0]                   v;
		logic [DIG_W-1:0]                   r;
		din     = {operand.digit_d, operand.digit_c, operand.digit_b, operand.digit_a};
		in_c.act  = operand.action;
		in_c.x    = operand.packed_in;
		in_c.acc  = '0;
		in_c.orig = operand.packed_in;
		for (int j = 0; j < FIELD_PLACES; j++) begin
			pl = place_of(cfg.n, cfg.be, 2'(j));
			v  = din[pl];
			r  = cfg.rsig[j];
			if (operand.action == ACT_PACK && CNT_W'(j) < cfg.n) begin
				in_c.ds[j] = (v >= r) ? r - DIG_W'(1) : v;
			end else begin
				in_c.ds[j] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		itm_s1 <= in_c;
	end

	assign lvl_vld[0]  = vld_s1;
	assign lvl_item[0] = itm_s1;

	for (genvar g = 0; g < FIELD_PLACES; g++) begin : g_lvl
		assign lvl_c[g].used = (CNT_W'(g) < cfg.n);
		assign lvl_c[g].r    = cfg.rsig[g];
		assign lvl_c[g].m    = cfg.msig[g];
		assign lvl_c[g].w    = cfg.wsig[g];

		mrc_level u_lvl (
			.clk     (clk),
			.arst_n  (arst_n),
			.lc      (lvl_c[g]),
			.in_vld  (lvl_vld[g]),
			.in_item (lvl_item[g]),
			.out_vld (lvl_vld[g+1]),
			.out_item(lvl_item[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s14 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			vld_s14 <= lvl_vld[FIELD_PLACES];
			done_q  <= vld_s14;
		end
	end

	always_ff @(posedge clk) begin
		itm_s14 <= lvl_item[FIELD_PLACES];
		t_s14   <= VAL_W'(lvl_item[FIELD_PLACES].x * cfg.prod);
		res_q   <= res_c;
	end

	// drop the excess above the top place; put digits back in place order
	always_comb begin
		logic [FIELD_PLACES-1:0][DIG_W-1:0] dout;
		logic [SUM_W-1:0]                   sum;
		sum = '0;
		for (int i = 0; i < FIELD_PLACES; i++) begin
			if (CNT_W'(i) < cfg.n) begin
				dout[i] = itm_s14.ds[place_of(cfg.n, cfg.be, 2'(i))];
			end else begin
				dout[i] = '0;
			end
			sum = sum + SUM_W'(itm_s14.ds[i]);
		end
		res_c.packed_out        = (itm_s14.act == ACT_UNPACK) ? itm_s14.orig - t_s14
			: itm_s14.acc;
		res_c.out_digit_a       = dout[0];
		res_c.out_digit_b       = dout[1];
		res_c.out_digit_c       = dout[2];
		res_c.out_digit_d       = dout[3];
		res_c.digit_sum         = sum;
		res_c.combination_count = cfg.prod;
	end

	assign done   = done_q;
	assign result = res_q;

	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted transaction produced no result");

	a_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without an accepted transaction");

	a_tail: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s14 |=> done)
		else $error("tail stage valid lost before output");

endmodule
`default_nettype wire

### sim/tb_top.sv
// Testbench for the mixed-radix codec core: directed table, corner settings, then checked random phases.
`timescale 1ns / 100ps
module tb_top import mrc_pkg::*; ();

	localparam int PLACES          = 4;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 62;
	localparam int QUIET_PHASE     = 3;
	localparam int STALL_LIMIT     = 4000;
	localparam int DRAIN_CYCLES    = 20;
	localparam int RESET_ROWS      = 6;
	localparam int PROBE_ROWS      = 4;
	localparam int CORNER_SETTINGS = 4;

	localparam logic [2:0] REG_UNMAPPED = 3'd7;

	typedef struct packed {
		codec_in_t  op;
		logic       known;
		codec_out_t want;
	} stim_row_t;

	typedef struct packed {
		logic [7:0] places;
		logic [7:0] ra;
		logic [7:0] rb;
		logic [7:0] rc;
		logic [7:0] rd;
		logic [7:0] order;
	} setting_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             start;
	logic             busy;
	codec_in_t        operand;
	logic             done;
	codec_out_t       result;
	logic             cfg_wr_en;
	logic [2:0]       cfg_idx;
	logic [DIG_W-1:0] cfg_data;

	// Shadow of the block's registers
	logic [2:0] cfg_places;
	logic [7:0] cfg_radix [FIELD_PLACES];
	logic       cfg_be;

	codec_out_t pending_results [$];
	codec_out_t want_result;
	int         mismatch_count = 0;
	int         stall_cycles = 0;

	// Defaults: four binary places, little-endian
	stim_row_t reset_rows [RESET_ROWS] = '{
		{{ACT_PACK, 8'd1, 8'd0, 8'd1, 8'd1, 32'hFFFFFFFF}, 1'b1,
			{32'd13, 8'd1, 8'd0, 8'd1, 8'd1, 10'd3, 32'd16}},
		{{ACT_PACK, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0}, 1'b1,
			{32'd0, 8'd0, 8'd0, 8'd0, 8'd0, 10'd0, 32'd16}},
		{{ACT_PACK, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'd0}, 1'b1,
			{32'd15, 8'd1, 8'd1, 8'd1, 8'd1, 10'd4, 32'd16}},
		{{ACT_UNPACK, 8'hA5, 8'h5A, 8'hFF, 8'h00, 32'hFFFFFFFF}, 1'b1,
			{32'd15, 8'd1, 8'd1, 8'd1, 8'd1, 10'd4, 32'd16}},
		{{ACT_UNPACK, 8'd0, 8'd0, 8'd0, 8'd0, 32'd13}, 1'b1,
			{32'd13, 8'd1, 8'd0, 8'd1, 8'd1, 10'd3, 32'd16}},
		{{ACT_UNPACK, 8'd0, 8'd0, 8'd0, 8'd0, 32'h10}, 1'b1,
			{32'd0, 8'd0, 8'd0, 8'd0, 8'd0, 10'd0, 32'd16}}
	};

	codec_in_t probe_ops [PROBE_ROWS] = '{
		{ACT_PACK, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'd0},
		{ACT_PACK, 8'd7, 8'd200, 8'd3, 8'd128, 32'hFFFF0000},
		{ACT_UNPACK, 8'd0, 8'd0, 8'd0, 8'd0, 32'hFFFFFFFF},
		{ACT_UNPACK, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 32'h89ABCDEF}
	};

	// Place count zero and above four, zero and unit radices, widest product, both orders
	setting_t corner_settings [CORNER_SETTINGS] = '{
		{8'hF8, 8'd255, 8'd255, 8'd255, 8'd255, 8'd1},
		{8'd7, 8'd255, 8'd255, 8'd255, 8'd255, 8'hFE},
		{8'd3, 8'd0, 8'd1, 8'd10, 8'd255, 8'd1},
		{8'd2, 8'd255, 8'd128, 8'd3, 8'd0, 8'd0}
	};

	mixed_radix_codec_core #(.PLACES(PLACES)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.operand   (operand),
		.done      (done),
		.result    (result),
		.cfg_wr_en (cfg_wr_en),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic codec_out_t predict_conversion(input codec_in_t op);
		logic [7:0]  rad [FIELD_PLACES];
		logic [7:0]  in_dig [FIELD_PLACES];
		logic [7:0]  dig [FIELD_PLACES];
		logic [63:0] prod;
		logic [63:0] val;
		logic [63:0] rest;
		logic [63:0] sum;
		int          n;
		int          lim;
		int          p;
		codec_out_t  res;
		lim = (PLACES < FIELD_PLACES) ? PLACES : FIELD_PLACES;
		if (lim < 1) lim = 1;
		n = cfg_places;
		if (n < 1) n = 1;
		if (n > lim) n = lim;
		in_dig[0] = op.digit_a;
		in_dig[1] = op.digit_b;
		in_dig[2] = op.digit_c;
		in_dig[3] = op.digit_d;
		for (int i = 0; i < FIELD_PLACES; i++) begin
			rad[i] = (cfg_radix[i] == 8'd0) ? 8'd1 : cfg_radix[i];
			dig[i] = 8'd0;
		end
		prod = 64'd1;
		for (int i = 0; i < n; i++)
			prod = prod * rad[i];
		if (op.action == ACT_PACK) begin
			for (int i = 0; i < n; i++)
				dig[i] = (in_dig[i] >= rad[i]) ? rad[i] - 8'd1 : in_dig[i];
			val = 64'd0;
			for (int k = 0; k < n; k++) begin
				p = cfg_be ? k : n - 1 - k;
				val = val * rad[p] + dig[p];
			end
		end else begin
			rest = {32'd0, op.packed_in} % prod;
			val = rest;
			for (int k = 0; k < n; k++) begin
				p = cfg_be ? n - 1 - k : k;
				dig[p] = 8'(rest % rad[p]);
				rest = rest / rad[p];
			end
		end
		sum = 64'd0;
		for (int i = 0; i < n; i++)
			sum = sum + dig[i];
		res.packed_out        = val[31:0];
		res.out_digit_a       = dig[0];
		res.out_digit_b       = dig[1];
		res.out_digit_c       = dig[2];
		res.out_digit_d       = dig[3];
		res.digit_sum         = sum[9:0];
		res.combination_count = prod[31:0];
		return res;
	endfunction

	function automatic logic [7:0] pick_radix();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd255;
			3: return 8'd2;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic setting_t random_setting();
		setting_t s;
		s.places = 8'($urandom_range(0, 255));
		s.ra     = pick_radix();
		s.rb     = pick_radix();
		s.rc     = pick_radix();
		s.rd     = pick_radix();
		s.order  = 8'($urandom_range(0, 255));
		return s;
	endfunction

	function automatic codec_in_t random_operand();
		codec_in_t  op;
		logic [7:0] d [FIELD_PLACES];
		logic [7:0] lim;
		op.action    = $urandom_range(0, 1) ? ACT_UNPACK : ACT_PACK;
		op.packed_in = $urandom;
		case ($urandom_range(0, 3))
			0: op.packed_in = $urandom_range(0, 255);
			1: op.packed_in = 32'hFFFFFFFF - $urandom_range(0, 255);
			default: ;
		endcase
		// Mostly digits within their radix; the rest span the full byte range and may clamp
		for (int i = 0; i < FIELD_PLACES; i++) begin
			lim = (cfg_radix[i] == 8'd0) ? 8'd1 : cfg_radix[i];
			d[i] = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, lim - 1))
				: 8'($urandom_range(0, 255));
		end
		op.digit_a = d[0];
		op.digit_b = d[1];
		op.digit_c = d[2];
		op.digit_d = d[3];
		return op;
	endfunction

	task automatic send_item(input codec_in_t op, input logic known, input codec_out_t want);
		operand <= op;
		start   <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_results.push_back(known ? want : predict_conversion(op));
	endtask

	task automatic idle_cycles(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_drain();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
		cfg_wr_en <= 1'b1;
		cfg_idx   <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_PLACE_COUNT: cfg_places   = data[2:0];
			REG_RADIX_A:     cfg_radix[0] = data;
			REG_RADIX_B:     cfg_radix[1] = data;
			REG_RADIX_C:     cfg_radix[2] = data;
			REG_RADIX_D:     cfg_radix[3] = data;
			REG_BIG_ENDIAN:  cfg_be       = data[0];
			default: ;
		endcase
	endtask

	task automatic apply_setting(input setting_t s);
		write_reg(REG_PLACE_COUNT, s.places);
		write_reg(REG_RADIX_A, s.ra);
		write_reg(REG_RADIX_B, s.rb);
		write_reg(REG_RADIX_C, s.rc);
		write_reg(REG_RADIX_D, s.rd);
		write_reg(REG_BIG_ENDIAN, s.order);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic check_field(input string name, input logic [31:0] want_v,
		input logic [31:0] got_v);
		if (want_v !== got_v) begin
			mismatch_count++;
			$display("%0t: %s expected %0h, actual %0h", $time, name, want_v, got_v);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				$display("%0t: result expected none, actual %h", $time, result);
			end else begin
				want_result = pending_results.pop_front();
				check_field("packed_out", want_result.packed_out, result.packed_out);
				check_field("out_digit_a", want_result.out_digit_a, result.out_digit_a);
				check_field("out_digit_b", want_result.out_digit_b, result.out_digit_b);
				check_field("out_digit_c", want_result.out_digit_c, result.out_digit_c);
				check_field("out_digit_d", want_result.out_digit_d, result.out_digit_d);
				check_field("digit_sum", want_result.digit_sum, result.digit_sum);
				check_field("combination_count", want_result.combination_count,
					result.combination_count);
			end
		end
	end

	// Abort when no transaction moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		operand    = '0;
		cfg_wr_en  = 1'b0;
		cfg_idx    = '0;
		cfg_data   = '0;
		cfg_places = 3'd4;
		cfg_be     = 1'b0;
		for (int i = 0; i < FIELD_PLACES; i++)
			cfg_radix[i] = 8'd2;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < RESET_ROWS; r++)
			send_item(reset_rows[r].op, reset_rows[r].known, reset_rows[r].want);

		for (int s = 0; s < CORNER_SETTINGS; s++) begin
			wait_drain();
			apply_setting(corner_settings[s]);
			for (int r = 0; r < PROBE_ROWS; r++)
				send_item(probe_ops[r], 1'b0, '0);
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_drain();
			write_reg(REG_UNMAPPED, 8'($urandom_range(0, 255)));
			apply_setting(random_setting());
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				// Hold off now and then, except through one whole phase
				if (ph != QUIET_PHASE && $urandom_range(0, 99) < 15)
					idle_cycles(1);
				send_item(random_operand(), 1'b0, '0);
			end
		end

		wait_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
